FILE: rtl/ucws_pkg.sv
package ucws_pkg;

	// Default number of entries held by the queue.
	localparam int DEF_CAPACITY = 32;

	// Field widths of the command and result items.
	localparam int KIND_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 6;

	// Command codes.
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SORT   = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DUP      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_SORT
	} state_t;

	// Command item.
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
		logic                      ascending;
	} cmd_t;

	// Result item.
	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] data_out;
		logic [POS_W-1:0]          position;
		logic [COUNT_W-1:0]        count;
		logic                      is_empty;
		logic                      is_full;
	} result_t;

	// Per-cell control from the controller.
	typedef struct packed {
		logic load;       // take the insert value
		logic shift;      // take the right neighbor's entry
		logic sort_lo;    // left member of a compare-exchange pair
		logic sort_hi;    // right member of a compare-exchange pair
		logic ascending;  // sort direction
	} cell_ctl_t;

endpackage

FILE: rtl/ucws_stream_if.sv
interface ucws_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ucws_cell.sv
module ucws_cell import ucws_pkg::*; (
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic signed [VALUE_W-1:0] key,
	input  logic signed [VALUE_W-1:0] left_data,
	input  logic signed [VALUE_W-1:0] right_data,
	output logic signed [VALUE_W-1:0] data_q,
	output logic                      match
);

	logic signed [VALUE_W-1:0] data_d;
	logic                      swap_lo;
	logic                      swap_hi;

	// The pair swaps when its left member belongs after its right member.
	assign swap_lo = ctl.ascending ? (right_data < data_q) : (data_q < right_data);
	assign swap_hi = ctl.ascending ? (left_data > data_q) : (left_data < data_q);

	// Search and duplicate compare against the stored entry.
	assign match = (data_q == key);

	// Next entry: insert, shift forward on remove, or one sort exchange.
	always_comb begin
		data_d = data_q;
		if (ctl.load) begin
			data_d = key;
		end else if (ctl.shift) begin
			data_d = right_data;
		end else if (ctl.sort_lo && swap_lo) begin
			data_d = right_data;
		end else if (ctl.sort_hi && swap_hi) begin
			data_d = left_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

FILE: rtl/unique_queue_with_sort.sv
// Bounded queue of unique signed 32-bit values in arrival order, built as a row of CAPACITY
// cells, one entry per cell. Insert and search compare the key against every cell at once and
// remove takes the head entry from cell 0; a new command is taken each cycle while the result register
// is free or being read. Sort runs odd-even transposition exchanges between neighboring cells,
// one exchange phase per cycle, and takes no command meanwhile; its result follows right
// after the last phase. Each command yields exactly one result item with status, removed
// value, search position, count and the empty and full flags.
module unique_queue_with_sort import ucws_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic         clk,
	input logic         arst_n,
	ucws_stream_if.sink   cmd,
	ucws_stream_if.source res
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t                    state_q;
	state_t                    state_d;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_d;
	logic [IDX_W-1:0]          sort_cnt_q;
	logic                      sort_asc_q;
	logic                      res_valid_q;
	result_t                   res_q;
	result_t                   res_d;
	logic                      load_res;
	logic                      sorting;
	logic                      sort_start;
	logic                      accept;
	logic                      is_full_now;
	logic                      is_empty_now;
	logic                      ins_ok;
	logic                      rem_ok;
	logic                      any_hit;
	logic [IDX_W-1:0]          hit_idx;
	logic [CAPACITY-1:0]       match;
	logic [CAPACITY-1:0]       valid;
	logic [CAPACITY-1:0]       hit;
	logic signed [VALUE_W-1:0] cell_data [CAPACITY];
	logic [IDX_W+POS_W-1:0]    pos_wide;
	logic [CNT_W+COUNT_W-1:0]  cnt_wide;

	// Handshake and command decode.
	assign accept       = cmd.valid && cmd.ready;
	assign is_full_now  = (count_q == CNT_W'(CAPACITY));
	assign is_empty_now = (count_q == '0);
	assign ins_ok = accept && (cmd.data.kind == KIND_INSERT) && !is_full_now && !any_hit;
	assign rem_ok = accept && (cmd.data.kind == KIND_REMOVE) && !is_empty_now;
	assign sort_start = accept && (cmd.data.kind == KIND_SORT);

	// Row of cells with their neighbor links and per-cell control.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam logic ODD = ((g % 2) == 1);
		localparam logic HAS_LEFT = (g > 0);
		logic signed [VALUE_W-1:0] left_d;
		logic signed [VALUE_W-1:0] right_d;
		cell_ctl_t                 ctl;

		if (g == 0) begin : g_first
			assign left_d = cell_data[g];
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[g];
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end

		assign ctl.load      = ins_ok && (count_q == CNT_W'(g));
		assign ctl.shift     = rem_ok;
		assign ctl.sort_lo   = sorting && (sort_cnt_q[0] == ODD) && (CNT_W'(g + 1) < count_q);
		assign ctl.sort_hi   = sorting && HAS_LEFT && (sort_cnt_q[0] != ODD)
			&& (CNT_W'(g) < count_q);
		assign ctl.ascending = sort_asc_q;

		assign valid[g] = (CNT_W'(g) < count_q);
		assign hit[g]   = match[g] && valid[g];

		ucws_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.key        (cmd.data.value),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (cell_data[g]),
			.match      (match[g])
		);
	end

	// Entries are unique, so at most one cell hits and its index is an OR of indices.
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end
	assign any_hit = |hit;

	// Next count.
	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign pos_wide = {{POS_W{1'b0}}, hit_idx};
	assign cnt_wide = {{COUNT_W{1'b0}}, count_d};

	// Result item, built from the state after the command.
	always_comb begin
		res_d          = '0;
		res_d.status   = STAT_DONE;
		res_d.count    = cnt_wide[COUNT_W-1:0];
		res_d.is_empty = (count_d == '0);
		res_d.is_full  = (count_d == CNT_W'(CAPACITY));
		if (state_q == ST_IDLE) begin
			case (cmd.data.kind)
				KIND_INSERT: begin
					if (is_full_now) begin
						res_d.status = STAT_FULL;
					end else if (any_hit) begin
						res_d.status = STAT_DUP;
					end
				end
				KIND_REMOVE: begin
					if (is_empty_now) begin
						res_d.status = STAT_EMPTY;
					end else begin
						res_d.data_out = cell_data[0];
					end
				end
				KIND_SEARCH: begin
					if (any_hit) begin
						res_d.position = pos_wide[POS_W-1:0];
					end else begin
						res_d.status = STAT_NOTFOUND;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Controller: next state and strobes.
	always_comb begin
		state_d   = state_q;
		sorting   = 1'b0;
		load_res  = 1'b0;
		cmd.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = !res_valid_q || res.ready;
				if (sort_start) begin
					state_d = ST_SORT;
				end else if (accept) begin
					load_res = 1'b1;
				end
			end
			ST_SORT: begin
				sorting = 1'b1;
				if (sort_cnt_q == IDX_W'(CAPACITY - 1)) begin
					state_d  = ST_IDLE;
					load_res = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sort_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (sort_start) begin
				sort_cnt_q <= '0;
			end else if (sorting) begin
				sort_cnt_q <= sort_cnt_q + IDX_W'(1);
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (sort_start) begin
			sort_asc_q <= cmd.data.ascending;
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

`ifndef NO_ASSERTIONS
	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	// Stored entries stay unique, so no two valid cells hit one key.
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("more than one valid cell matches the key");

	// No command is taken while the cells sort.
	a_sort_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> !cmd.ready)
		else $error("command accepted during sort");

	// A successful insert grows the count by one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not advance the count");

	// A result is never loaded over one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |-> (!res_valid_q || res.ready))
		else $error("result register overwritten");
`endif

endmodule
